FILE: rtl/assert_macros.svh
// Assertion macros used by the port-level checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, clocked on clk_i, off while rst_ni is low.
`define URLB_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("urlb assertion failed");

// Next-cycle implication, clocked on clk_i, off while rst_ni is low.
`define URLB_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("urlb assertion failed");

`endif

FILE: rtl/urlb_pkg.sv
// Types and constants of the UART receive line buffer.
package urlb_pkg;

  localparam int ByteW       = 8;
  localparam int ActW        = 2;
  localparam int ResultLimit = 64;
  localparam int CntW        = 7;

  localparam logic [ByteW-1:0] TermReset = 8'd13;
  localparam logic [CntW-1:0]  CntLast   = 7'(ResultLimit - 1);

  typedef enum logic [ActW-1:0] {
    ACT_PUSH   = 2'd0,
    ACT_POP    = 2'd1,
    ACT_SEARCH = 2'd2,
    ACT_LINE   = 2'd3
  } action_e;

  typedef struct packed {
    logic data_valid;
    logic char_found;
    logic line_ended;
    logic push_dropped;
    logic run_last;
  } urlb_flags_t;

  typedef struct packed {
    logic [ByteW-1:0] data_byte;
    urlb_flags_t      flags;
  } urlb_res_t;

  typedef struct packed {
    logic        push_wr;
    logic        rd_en;
    logic        rd_scan;
    logic        scan_init;
    logic        latch_sought;
    logic        pop_adv;
    logic        cnt_clr;
    logic        res_load;
    urlb_flags_t flags;
    logic        out_load;
  } urlb_cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
    logic scan_end;
    logic match;
    logic term;
    logic last_byte;
    logic slot_free;
  } urlb_sts_t;

endpackage

FILE: rtl/urlb_in_if.sv
// Input channel: one action beat with its byte.
interface urlb_in_if;
  logic                        valid;
  logic                        ready;
  logic [urlb_pkg::ActW-1:0]   action;
  logic [urlb_pkg::ByteW-1:0]  byte_value;

  modport source (output valid, action, byte_value, input ready);
  modport sink   (input valid, action, byte_value, output ready);
endinterface

FILE: rtl/urlb_out_if.sv
// Output channel: one result beat.
interface urlb_out_if;
  logic                        valid;
  logic                        ready;
  logic [urlb_pkg::ByteW-1:0]  data_byte;
  logic                        data_valid;
  logic                        char_found;
  logic                        line_ended;
  logic                        push_dropped;
  logic                        run_last;

  modport source (output valid, data_byte, data_valid, char_found, line_ended, push_dropped,
                  run_last, input ready);
  modport sink   (input valid, data_byte, data_valid, char_found, line_ended, push_dropped,
                  run_last, output ready);
endinterface

FILE: rtl/urlb_ram.sv
// Generic single-write, single-read RAM with registered read data.
module urlb_ram #(
  parameter int Width = 8,
  parameter int Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/urlb_ctrl.sv
// Controller state machine: sequences push, pop, search and line read.
module urlb_ctrl (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  input  logic [urlb_pkg::ActW-1:0]     action_i,
  input  urlb_pkg::urlb_sts_t           sts_i,
  output logic                          in_ready_o,
  output urlb_pkg::urlb_cmd_t           cmd_o
);

  typedef enum logic [5:0] {
    S_IDLE     = 6'b000001,
    S_POP      = 6'b000010,
    S_SCAN     = 6'b000100,
    S_LINE_CHK = 6'b001000,
    S_EMIT     = 6'b010000,
    S_SPARE    = 6'b100000
  } state_e;

  state_e state_q, state_d;
  logic   pend_q, pend_d;
  logic   more_q, more_d;

  always_comb begin
    state_d    = state_q;
    pend_d     = pend_q;
    more_d     = more_q;
    in_ready_o = 1'b0;
    cmd_o      = '0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        more_d     = 1'b0;
        if (in_valid_i) begin
          unique case (urlb_pkg::action_e'(action_i))
            urlb_pkg::ACT_PUSH: begin
              cmd_o.push_wr            = !sts_i.full;
              cmd_o.res_load           = 1'b1;
              cmd_o.flags.push_dropped = sts_i.full;
              cmd_o.flags.run_last     = 1'b1;
              state_d                  = S_EMIT;
            end
            urlb_pkg::ACT_POP: begin
              if (sts_i.empty) begin
                cmd_o.res_load       = 1'b1;
                cmd_o.flags.run_last = 1'b1;
                state_d              = S_EMIT;
              end else begin
                cmd_o.rd_en = 1'b1;
                state_d     = S_POP;
              end
            end
            urlb_pkg::ACT_SEARCH: begin
              cmd_o.scan_init    = 1'b1;
              cmd_o.latch_sought = 1'b1;
              pend_d             = 1'b0;
              state_d            = S_SCAN;
            end
            urlb_pkg::ACT_LINE: begin
              cmd_o.cnt_clr = 1'b1;
              if (sts_i.empty) begin
                cmd_o.res_load       = 1'b1;
                cmd_o.flags.run_last = 1'b1;
                state_d              = S_EMIT;
              end else begin
                cmd_o.rd_en = 1'b1;
                state_d     = S_LINE_CHK;
              end
            end
            default: state_d = S_IDLE;
          endcase
        end
      end
      S_POP: begin
        cmd_o.pop_adv          = 1'b1;
        cmd_o.res_load         = 1'b1;
        cmd_o.flags.data_valid = 1'b1;
        cmd_o.flags.run_last   = 1'b1;
        state_d                = S_EMIT;
      end
      S_SCAN: begin
        // one entry issued per cycle, compared when its data returns
        if (pend_q && sts_i.match) begin
          cmd_o.res_load         = 1'b1;
          cmd_o.flags.char_found = 1'b1;
          cmd_o.flags.run_last   = 1'b1;
          state_d                = S_EMIT;
        end else if (sts_i.scan_end) begin
          cmd_o.res_load       = 1'b1;
          cmd_o.flags.run_last = 1'b1;
          state_d              = S_EMIT;
        end else begin
          cmd_o.rd_en   = 1'b1;
          cmd_o.rd_scan = 1'b1;
          pend_d        = 1'b1;
        end
      end
      S_LINE_CHK: begin
        cmd_o.pop_adv  = 1'b1;
        cmd_o.res_load = 1'b1;
        if (sts_i.term) begin
          cmd_o.flags.line_ended = 1'b1;
          cmd_o.flags.run_last   = 1'b1;
          more_d                 = 1'b0;
        end else begin
          cmd_o.flags.data_valid = 1'b1;
          cmd_o.flags.run_last   = sts_i.last_byte;
          more_d                 = !sts_i.last_byte;
        end
        state_d = S_EMIT;
      end
      S_EMIT: begin
        if (sts_i.slot_free) begin
          cmd_o.out_load = 1'b1;
          if (more_q) begin
            cmd_o.rd_en = 1'b1;
            state_d     = S_LINE_CHK;
          end else begin
            state_d = S_IDLE;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      pend_q  <= 1'b0;
      more_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      pend_q  <= pend_d;
      more_q  <= more_d;
    end
  end

endmodule

FILE: rtl/urlb_dp.sv
// Datapath: ring pointers, byte store, terminator register and result registers.
module urlb_dp #(
  parameter int DEPTH_LOG2 = 6
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [urlb_pkg::ByteW-1:0]   cfg_wdata_i,
  input  logic [urlb_pkg::ByteW-1:0]   byte_value_i,
  input  logic                         out_ready_i,
  input  urlb_pkg::urlb_cmd_t          cmd_i,
  output urlb_pkg::urlb_sts_t          sts_o,
  output logic                         out_valid_o,
  output urlb_pkg::urlb_res_t          out_o
);

  localparam int Depth = 1 << DEPTH_LOG2;

  logic [DEPTH_LOG2-1:0]      rd_q, wr_q, scan_q;
  logic [DEPTH_LOG2-1:0]      rd_inc, wr_inc, raddr;
  logic [urlb_pkg::CntW-1:0]  cnt_q;
  logic [urlb_pkg::ByteW-1:0] term_q, sought_q, rdata;
  urlb_pkg::urlb_res_t        res_q, out_q;
  logic                       out_valid_q;

  assign rd_inc = rd_q + DEPTH_LOG2'(1);
  assign wr_inc = wr_q + DEPTH_LOG2'(1);
  assign raddr  = cmd_i.rd_scan ? scan_q : rd_q;

  urlb_ram #(
    .Width(urlb_pkg::ByteW),
    .Depth(Depth)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (cmd_i.push_wr),
    .waddr_i(wr_q),
    .wdata_i(byte_value_i),
    .re_i   (cmd_i.rd_en),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  always_comb begin
    sts_o.full      = (wr_inc == rd_q);
    sts_o.empty     = (rd_q == wr_q);
    sts_o.scan_end  = (scan_q == wr_q);
    sts_o.match     = (rdata == sought_q);
    sts_o.term      = (rdata == term_q);
    sts_o.last_byte = (rd_inc == wr_q) || (cnt_q == urlb_pkg::CntLast);
    sts_o.slot_free = !out_valid_q || out_ready_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_q        <= '0;
      wr_q        <= '0;
      term_q      <= urlb_pkg::TermReset;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        term_q <= cfg_wdata_i;
      end
      if (cmd_i.push_wr) begin
        wr_q <= wr_inc;
      end
      if (cmd_i.pop_adv) begin
        rd_q <= rd_inc;
      end
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.cnt_clr) begin
      cnt_q <= '0;
    end else if (cmd_i.pop_adv) begin
      cnt_q <= cnt_q + urlb_pkg::CntW'(1);
    end
    if (cmd_i.scan_init) begin
      scan_q <= rd_q;
    end else if (cmd_i.rd_en && cmd_i.rd_scan) begin
      scan_q <= scan_q + DEPTH_LOG2'(1);
    end
    if (cmd_i.latch_sought) begin
      sought_q <= byte_value_i;
    end
    if (cmd_i.res_load) begin
      res_q.data_byte <= cmd_i.flags.data_valid ? rdata : '0;
      res_q.flags     <= cmd_i.flags;
    end
    if (cmd_i.out_load) begin
      out_q <= res_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

endmodule

FILE: rtl/uart_rx_line_buffer_core.sv
// Push, empty pop and empty line read load the result register at accept, pop after its
// store read. Search walks the unread bytes; the byte store read port gives one per cycle.
// Line read does a store read and a result load for each popped byte.
// One item is worked at a time; a new item is taken while the last result beat still waits.
// Reset: read and write pointers cleared (ring empty), terminator set to 13, output register empty.
// The byte store is not cleared; only written entries are ever read.
module uart_rx_line_buffer_core #(
  parameter int DEPTH_LOG2 = 6
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [urlb_pkg::ByteW-1:0]  cfg_wdata_i,
  urlb_in_if.sink                     in_ch,
  urlb_out_if.source                  out_ch
);

  urlb_pkg::urlb_cmd_t cmd;
  urlb_pkg::urlb_sts_t sts;
  urlb_pkg::urlb_res_t out_res;
  logic                out_valid;
  logic                in_ready;

  urlb_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_ch.valid),
    .action_i  (in_ch.action),
    .sts_i     (sts),
    .in_ready_o(in_ready),
    .cmd_o     (cmd)
  );

  urlb_dp #(
    .DEPTH_LOG2(DEPTH_LOG2)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .byte_value_i(in_ch.byte_value),
    .out_ready_i (out_ch.ready),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (out_valid),
    .out_o       (out_res)
  );

  assign in_ch.ready         = in_ready;
  assign out_ch.valid        = out_valid;
  assign out_ch.data_byte    = out_res.data_byte;
  assign out_ch.data_valid   = out_res.flags.data_valid;
  assign out_ch.char_found   = out_res.flags.char_found;
  assign out_ch.line_ended   = out_res.flags.line_ended;
  assign out_ch.push_dropped = out_res.flags.push_dropped;
  assign out_ch.run_last     = out_res.flags.run_last;

endmodule

FILE: rtl/urlb_checker.sv
// Port-level checker for the line buffer, bound to the top level.
`include "assert_macros.svh"

module urlb_sva (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        in_valid_i,
  input logic                        in_ready_i,
  input logic                        out_valid_i,
  input logic                        out_ready_i,
  input logic [urlb_pkg::ByteW-1:0]  out_data_byte_i,
  input logic                        out_data_valid_i,
  input logic                        out_run_last_i
);

  // an accepted beat always keeps the block busy for the next cycle
  `URLB_ASSERT_NEXT(a_busy_after_accept, in_valid_i && in_ready_i, !in_ready_i)

  // a run still in progress holds off new input
  `URLB_ASSERT_IMPL(a_no_accept_mid_run, out_valid_i && !out_run_last_i, !in_ready_i)

  `URLB_ASSERT_IMPL(a_byte_zero_unless_valid, out_valid_i && !out_data_valid_i,
                    out_data_byte_i == '0)

  `URLB_ASSERT_NEXT(a_out_hold, out_valid_i && !out_ready_i,
                    out_valid_i && $stable(out_data_byte_i) && $stable(out_run_last_i))

endmodule

bind uart_rx_line_buffer_core urlb_sva u_urlb_sva (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_valid_i      (in_ch.valid),
  .in_ready_i      (in_ch.ready),
  .out_valid_i     (out_ch.valid),
  .out_ready_i     (out_ch.ready),
  .out_data_byte_i (out_ch.data_byte),
  .out_data_valid_i(out_ch.data_valid),
  .out_run_last_i  (out_ch.run_last)
);

FILE: tb/sv/urlb_checker.sv
// Checker for the line buffer: mirrors the ring on accepted beats and compares results.
`timescale 1ns / 1ps
module urlb_checker #(
  parameter int DEPTH_LOG2 = 6
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [urlb_pkg::ByteW-1:0] cfg_wdata_i,
  urlb_in_if                         in_ch,
  urlb_out_if                        out_ch,
  output int                         err_cnt_o,
  output int                         owed_cnt_o
);

  localparam int ByteW    = urlb_pkg::ByteW;
  localparam int RingSize = 1 << DEPTH_LOG2;

  logic [ByteW-1:0]      ring_mem [RingSize];
  logic [DEPTH_LOG2-1:0] rd_idx;
  logic [DEPTH_LOG2-1:0] wr_idx;
  logic [ByteW-1:0]      term_char;
  urlb_pkg::urlb_res_t   owed_beats [$];

  function automatic urlb_pkg::urlb_res_t mk_beat(logic [ByteW-1:0] b, logic dv, logic cf,
                                                  logic le, logic pd);
    urlb_pkg::urlb_res_t r;
    r.data_byte          = b;
    r.flags.data_valid   = dv;
    r.flags.char_found   = cf;
    r.flags.line_ended   = le;
    r.flags.push_dropped = pd;
    r.flags.run_last     = 1'b0;
    return r;
  endfunction

  task automatic apply_action(urlb_pkg::action_e act, logic [ByteW-1:0] val);
    urlb_pkg::urlb_res_t   run [$];
    logic [DEPTH_LOG2-1:0] nxt;
    logic [DEPTH_LOG2-1:0] idx;
    logic [ByteW-1:0]      b;
    logic                  hit;
    case (act)
      urlb_pkg::ACT_PUSH: begin
        nxt = wr_idx + DEPTH_LOG2'(1);
        if (nxt == rd_idx) begin
          run.push_back(mk_beat('0, 1'b0, 1'b0, 1'b0, 1'b1));
        end else begin
          ring_mem[wr_idx] = val;
          wr_idx = nxt;
          run.push_back(mk_beat('0, 1'b0, 1'b0, 1'b0, 1'b0));
        end
      end
      urlb_pkg::ACT_POP: begin
        if (rd_idx == wr_idx) begin
          run.push_back(mk_beat('0, 1'b0, 1'b0, 1'b0, 1'b0));
        end else begin
          run.push_back(mk_beat(ring_mem[rd_idx], 1'b1, 1'b0, 1'b0, 1'b0));
          rd_idx = rd_idx + DEPTH_LOG2'(1);
        end
      end
      urlb_pkg::ACT_SEARCH: begin
        idx = rd_idx;
        hit = 1'b0;
        while (idx != wr_idx && !hit) begin
          if (ring_mem[idx] == val) hit = 1'b1;
          idx = idx + DEPTH_LOG2'(1);
        end
        run.push_back(mk_beat('0, 1'b0, hit, 1'b0, 1'b0));
      end
      default: begin
        while (run.size() < urlb_pkg::ResultLimit && rd_idx != wr_idx) begin
          b = ring_mem[rd_idx];
          rd_idx = rd_idx + DEPTH_LOG2'(1);
          if (b == term_char) begin
            run.push_back(mk_beat('0, 1'b0, 1'b0, 1'b1, 1'b0));
            break;
          end
          run.push_back(mk_beat(b, 1'b1, 1'b0, 1'b0, 1'b0));
        end
        if (run.size() == 0) run.push_back(mk_beat('0, 1'b0, 1'b0, 1'b0, 1'b0));
      end
    endcase
    run[run.size()-1].flags.run_last = 1'b1;
    foreach (run[k]) owed_beats.push_back(run[k]);
  endtask

  // flags print as dv, cf, le, pd, last
  always @(posedge clk_i or negedge rst_ni) begin
    urlb_pkg::urlb_res_t got;
    urlb_pkg::urlb_res_t want;
    if (!rst_ni) begin
      rd_idx = '0;
      wr_idx = '0;
      term_char = urlb_pkg::TermReset;
      owed_beats.delete();
      err_cnt_o = 0;
      owed_cnt_o = 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        got.data_byte          = out_ch.data_byte;
        got.flags.data_valid   = out_ch.data_valid;
        got.flags.char_found   = out_ch.char_found;
        got.flags.line_ended   = out_ch.line_ended;
        got.flags.push_dropped = out_ch.push_dropped;
        got.flags.run_last     = out_ch.run_last;
        if (owed_beats.size() == 0) begin
          err_cnt_o++;
          $display("%0t: result beat with none pending: exp none, act byte=%h flags=%b",
                   $time, got.data_byte, got.flags);
        end else begin
          want = owed_beats.pop_front();
          if (got !== want) begin
            err_cnt_o++;
            $display("%0t: mismatch exp byte=%h flags=%b, act byte=%h flags=%b",
                     $time, want.data_byte, want.flags, got.data_byte, got.flags);
          end
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        apply_action(urlb_pkg::action_e'(in_ch.action), in_ch.byte_value);
      end
      if (cfg_we_i) term_char = cfg_wdata_i;
      owed_cnt_o = owed_beats.size();
    end
  end

endmodule

FILE: tb/sv/testbench.sv
// Testbench top for the UART receive line buffer: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps
module testbench;

  localparam int ByteW        = urlb_pkg::ByteW;
  localparam int DepthLog2    = 6;
  localparam int RingSlots    = (1 << DepthLog2) - 1;
  localparam int CycleLimit   = 1_000_000;
  localparam int SettleCycles = 16;
  localparam int PhaseItems   = 70;
  localparam int HoldCycles   = 500;

  localparam logic [ByteW-1:0] ChX  = 8'h78;
  localparam logic [ByteW-1:0] ChY  = 8'h79;
  localparam logic [ByteW-1:0] ChZ  = 8'h7A;
  localparam logic [ByteW-1:0] ChCr = 8'h0D;

  logic             clk_i = 1'b0;
  logic             rst_ni;
  logic             cfg_we_i;
  logic [ByteW-1:0] cfg_wdata_i;

  int send_idle_pct;
  int recv_stall_pct;
  int hold_len = 0;
  int hold_left = 0;
  bit hold_taken = 1'b0;
  int cycle_cnt = 0;
  int sent_cnt = 0;
  int err_cnt;
  int owed_cnt;

  urlb_in_if  in_ch ();
  urlb_out_if out_ch ();

  uart_rx_line_buffer_core #(
    .DEPTH_LOG2(DepthLog2)
  ) i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_ch      (in_ch),
    .out_ch     (out_ch)
  );

  urlb_checker #(
    .DEPTH_LOG2(DepthLog2)
  ) i_checker (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .err_cnt_o  (err_cnt),
    .owed_cnt_o (owed_cnt)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // receiver: random stalls, or a counted hold-off requested once by the stimulus
  always @(negedge clk_i) begin
    if (!hold_taken && hold_len > 0) begin
      hold_taken = 1'b1;
      hold_left = hold_len;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CycleLimit) begin
      $display("Verification failed");
      $finish;
    end
  end

  task automatic send_beat(urlb_pkg::action_e act, logic [ByteW-1:0] val);
    @(negedge clk_i);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      in_ch.byte_value <= ByteW'($urandom);
      @(negedge clk_i);
    end
    in_ch.valid <= 1'b1;
    in_ch.action <= act;
    in_ch.byte_value <= val;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    sent_cnt++;
  endtask

  // stop offering beats until every result is back, then let the block go quiet
  task automatic settle();
    @(negedge clk_i);
    in_ch.valid <= 1'b0;
    while (owed_cnt != 0) @(negedge clk_i);
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  task automatic write_term(logic [ByteW-1:0] t);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= t;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  function automatic logic [ByteW-1:0] pick_char(logic [ByteW-1:0] term);
    case ($urandom_range(9))
      0: return ChX;
      1: return ChY;
      2: return ChZ;
      3: return ChCr;
      4: return term;
      default: return ByteW'($urandom);
    endcase
  endfunction

  // mostly whole lines (bytes, terminator, search, line read), some loose beats
  task automatic run_traffic(int n_items, logic [ByteW-1:0] term);
    int goal;
    int len;
    goal = sent_cnt + n_items;
    while (sent_cnt < goal) begin
      if ($urandom_range(99) < 65) begin
        len = $urandom_range(0, 10);
        repeat (len) send_beat(urlb_pkg::ACT_PUSH, pick_char(term));
        if ($urandom_range(99) < 80) send_beat(urlb_pkg::ACT_PUSH, term);
        if ($urandom_range(1) == 1) send_beat(urlb_pkg::ACT_SEARCH, pick_char(term));
        send_beat(urlb_pkg::ACT_LINE, ByteW'($urandom));
      end else begin
        send_beat(urlb_pkg::action_e'($urandom_range(3)), pick_char(term));
      end
    end
  endtask

  initial begin
    logic [ByteW-1:0] t;
    logic [ByteW-1:0] b;
    logic [ByteW-1:0] first_b;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_wdata_i = '0;
    in_ch.valid = 1'b0;
    in_ch.action = urlb_pkg::ACT_PUSH;
    in_ch.byte_value = '0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // empty ring, then a CR line at the reset terminator, then a line with no terminator
    send_beat(urlb_pkg::ACT_LINE, 8'h00);
    send_beat(urlb_pkg::ACT_POP, 8'hFF);
    send_beat(urlb_pkg::ACT_SEARCH, ChX);
    send_beat(urlb_pkg::ACT_PUSH, 8'h00);
    send_beat(urlb_pkg::ACT_PUSH, 8'hFF);
    send_beat(urlb_pkg::ACT_PUSH, ChX);
    send_beat(urlb_pkg::ACT_PUSH, ChCr);
    send_beat(urlb_pkg::ACT_PUSH, ChY);
    send_beat(urlb_pkg::ACT_SEARCH, ChX);
    send_beat(urlb_pkg::ACT_SEARCH, ChZ);
    send_beat(urlb_pkg::ACT_SEARCH, 8'hFF);
    send_beat(urlb_pkg::ACT_SEARCH, ChCr);
    send_beat(urlb_pkg::ACT_LINE, 8'hA5);
    send_beat(urlb_pkg::ACT_POP, 8'h5A);
    send_beat(urlb_pkg::ACT_POP, 8'h00);
    send_beat(urlb_pkg::ACT_PUSH, 8'h55);
    send_beat(urlb_pkg::ACT_PUSH, 8'hAA);
    send_beat(urlb_pkg::ACT_LINE, 8'hFF);
    send_beat(urlb_pkg::ACT_SEARCH, 8'h55);
    settle();

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  t = 8'h0A; end
        1: begin send_idle_pct = 83; recv_stall_pct = 0;  t = 8'h00; end
        2: begin send_idle_pct = 0;  recv_stall_pct = 83; t = 8'hFF; end
        default: begin send_idle_pct = 8; recv_stall_pct = 8; t = ByteW'($urandom); end
      endcase
      write_term(t);
      run_traffic(PhaseItems, t);
      settle();
    end

    // empty the ring, then overfill it behind a long receiver hold-off
    send_idle_pct = 0;
    recv_stall_pct = 0;
    t = ChZ;
    write_term(t);
    repeat (RingSlots) send_beat(urlb_pkg::ACT_POP, ByteW'($urandom));
    settle();
    @(posedge clk_i);
    hold_len = HoldCycles;
    first_b = 8'h00;
    for (int i = 0; i < RingSlots + 7; i++) begin
      b = ByteW'($urandom);
      if (b == t) b ^= 8'h01;
      if (i == 0) first_b = b;
      send_beat(urlb_pkg::ACT_PUSH, b);
    end
    send_beat(urlb_pkg::ACT_SEARCH, first_b);
    send_beat(urlb_pkg::ACT_SEARCH, t);
    send_beat(urlb_pkg::ACT_LINE, 8'h00);
    send_beat(urlb_pkg::ACT_PUSH, t);
    send_beat(urlb_pkg::ACT_LINE, 8'hFF);
    settle();

    if (err_cnt == 0 && owed_cnt == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
